### hdl/climate_panel_mode_controller_unit_assert.svh
// Assertion macros for the climate panel controller.
// Uses the clk and rst_n names of the module that includes this header.
`ifndef CLIMATE_PANEL_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define CLIMATE_PANEL_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CPMC_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cpmc assertion failed");

// Next-cycle implication, checked out of reset
`define CPMC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cpmc assertion failed");

`endif

### hdl/cpmc_pkg.sv
// Shared types and constants for the climate panel controller.
// No dependencies; the design modules refer to it by scoped names, the bench imports it.
package cpmc_pkg;

    // Fan level limits
    localparam logic [3:0] SPEED_MIN = 4'd1;
    localparam logic [3:0] SPEED_MAX = 4'd8;

    // Update flag masks
    localparam logic [4:0] FL_TEMP = 5'b00001;
    localparam logic [4:0] FL_AIR  = 5'b00010;
    localparam logic [4:0] FL_EXT  = 5'b00100;
    localparam logic [4:0] FL_FAN  = 5'b01000;
    localparam logic [4:0] FL_UI   = 5'b10000;

    typedef enum logic [1:0] {
        ST_RESET = 2'd0,
        ST_OFF   = 2'd1,
        ST_ON    = 2'd2
    } status_t;

    // Button event codes
    typedef enum logic [3:0] {
        EV_RESTORE    = 4'd0,
        EV_OFF        = 4'd1,
        EV_AUTO       = 4'd2,
        EV_ECONOMY    = 4'd3,
        EV_RECIRC     = 4'd4,
        EV_TEMP_UP    = 4'd5,
        EV_TEMP_DOWN  = 4'd6,
        EV_OUTSIDE    = 4'd7,
        EV_FAN_UP     = 4'd8,
        EV_FAN_DOWN   = 4'd9,
        EV_AIR_SELECT = 4'd10
    } kind_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PRESET_ECONOMY = 3'd0,
        CFG_PRESET_RECIRC  = 3'd1,
        CFG_PRESET_AIR     = 3'd2,
        CFG_PRESET_TEMP    = 3'd3,
        CFG_PRESET_FAN     = 3'd4,
        CFG_TEMP_FLOOR     = 3'd5,
        CFG_TEMP_CEILING   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic       preset_economy;
        logic       preset_recirculate;
        logic [2:0] preset_air_position;
        logic [7:0] preset_temperature;
        logic [3:0] preset_fan_speed;
        logic [7:0] temperature_floor;
        logic [7:0] temperature_ceiling;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic       auto_on;
        logic       economy;
        logic       recirculate;
        logic [7:0] temperature;
        logic [3:0] fan;
        logic [2:0] air;
        logic [4:0] flags;
    } panel_state_t;

    localparam panel_state_t STATE_RESET = '{
        status:      ST_RESET,
        auto_on:     1'b0,
        economy:     1'b0,
        recirculate: 1'b0,
        temperature: 8'd0,
        fan:         4'd0,
        air:         3'd0,
        flags:       5'd0
    };

endpackage

### hdl/cpmc_in_if.sv
// Button event channel: valid/ready handshake with the event payload.
// No dependencies.
interface cpmc_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [2:0] air_position;
    logic       last_was_on;
    logic [4:0] clear_mask;

    modport source (output valid, kind, air_position, last_was_on, clear_mask,
                    input ready);
    modport sink   (input valid, kind, air_position, last_was_on, clear_mask,
                    output ready);
endinterface

### hdl/cpmc_out_if.sv
// Panel state channel: valid/ready handshake with the full reported state.
// No dependencies.
interface cpmc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] unit_status;
    logic       auto_mode;
    logic       economy_mode;
    logic       recirculate_mode;
    logic [7:0] set_temperature;
    logic [3:0] fan_level;
    logic [2:0] air_setting;
    logic [4:0] update_flags;

    modport source (output valid, unit_status, auto_mode, economy_mode, recirculate_mode,
                    set_temperature, fan_level, air_setting, update_flags,
                    input ready);
    modport sink   (input valid, unit_status, auto_mode, economy_mode, recirculate_mode,
                    set_temperature, fan_level, air_setting, update_flags,
                    output ready);
endinterface

### hdl/cpmc_cfg_regs.sv
// Preset and temperature limit registers of the climate panel controller.
// Depends on cpmc_pkg.
module cpmc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output cpmc_pkg::cfg_t     cfg
);

    cpmc_pkg::cfg_t cfg_reg;
    cpmc_pkg::cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cpmc_pkg::CFG_PRESET_ECONOMY: cfg_next.preset_economy      = cfg_data[0];
                cpmc_pkg::CFG_PRESET_RECIRC:  cfg_next.preset_recirculate  = cfg_data[0];
                cpmc_pkg::CFG_PRESET_AIR:     cfg_next.preset_air_position = cfg_data[2:0];
                cpmc_pkg::CFG_PRESET_TEMP:    cfg_next.preset_temperature  = cfg_data;
                cpmc_pkg::CFG_PRESET_FAN:     cfg_next.preset_fan_speed    = cfg_data[3:0];
                cpmc_pkg::CFG_TEMP_FLOOR:     cfg_next.temperature_floor   = cfg_data;
                cpmc_pkg::CFG_TEMP_CEILING:   cfg_next.temperature_ceiling = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preset_economy      <= 1'b0;
            cfg_reg.preset_recirculate  <= 1'b0;
            cfg_reg.preset_air_position <= 3'd0;
            cfg_reg.preset_temperature  <= 8'd22;
            cfg_reg.preset_fan_speed    <= 4'd1;
            cfg_reg.temperature_floor   <= 8'd16;
            cfg_reg.temperature_ceiling <= 8'd30;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/cpmc_next_state.sv
// Next panel state for one button event: flag clear, then the event itself.
// Depends on cpmc_pkg. Purely combinational.
module cpmc_next_state (
    input  cpmc_pkg::panel_state_t cur,
    input  cpmc_pkg::cfg_t         cfg,
    input  logic [3:0]             kind,
    input  logic [2:0]             air_position,
    input  logic                   last_was_on,
    input  logic [4:0]             clear_mask,
    output cpmc_pkg::panel_state_t nxt
);

    logic       is_on;
    logic       auto_next;
    logic [8:0] temp_inc;
    logic [7:0] temp_dec;
    logic [3:0] fan_preset;

    // Saturation helpers
    assign is_on    = (cur.status == cpmc_pkg::ST_ON);
    assign temp_inc = {1'b0, cur.temperature} + 9'd1;
    assign temp_dec = cur.temperature - 8'd1;

    always_comb
    begin
        if (cfg.preset_fan_speed < cpmc_pkg::SPEED_MIN)
            fan_preset = cpmc_pkg::SPEED_MIN;
        else if (cfg.preset_fan_speed > cpmc_pkg::SPEED_MAX)
            fan_preset = cpmc_pkg::SPEED_MAX;
        else
            fan_preset = cfg.preset_fan_speed;
    end

    assign auto_next = is_on ? ~cur.auto_on : cur.auto_on;

    // Event decode
    always_comb
    begin
        nxt       = cur;
        nxt.flags = cur.flags & ~clear_mask;
        case (kind)
            cpmc_pkg::EV_RESTORE:
            begin
                if (last_was_on)
                begin
                    nxt.status = cpmc_pkg::ST_ON;
                    nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_AIR;
                end
                else
                begin
                    nxt.status = cpmc_pkg::ST_OFF;
                end
                nxt.flags = nxt.flags | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_OFF:
            begin
                if (is_on)
                begin
                    nxt.status = cpmc_pkg::ST_OFF;
                    nxt.flags  = nxt.flags
                               & ~(cpmc_pkg::FL_TEMP | cpmc_pkg::FL_AIR | cpmc_pkg::FL_EXT);
                    nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN;
                end
                nxt.flags = nxt.flags | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_AUTO:
            begin
                nxt.auto_on = auto_next;
                if (auto_next)
                begin
                    nxt.economy     = cfg.preset_economy;
                    nxt.recirculate = cfg.preset_recirculate;
                    nxt.air         = cfg.preset_air_position;
                    nxt.temperature = cfg.preset_temperature;
                    nxt.fan         = fan_preset;
                    nxt.flags       = (nxt.flags | cpmc_pkg::FL_AIR) & ~cpmc_pkg::FL_EXT;
                end
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_ECONOMY:
            begin
                nxt.auto_on = 1'b0;
                nxt.economy = is_on ? ~cur.economy : 1'b1;
                nxt.status  = cpmc_pkg::ST_ON;
                nxt.flags   = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_RECIRC:
            begin
                nxt.auto_on     = 1'b0;
                nxt.recirculate = is_on ? ~cur.recirculate : 1'b1;
                nxt.status      = cpmc_pkg::ST_ON;
                nxt.flags       = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_TEMP_UP:
            begin
                nxt.auto_on = 1'b0;
                if (is_on)
                begin
                    // saturate at the ceiling, also from above it
                    if (temp_inc > {1'b0, cfg.temperature_ceiling})
                        nxt.temperature = cfg.temperature_ceiling;
                    else
                        nxt.temperature = temp_inc[7:0];
                    nxt.flags = (nxt.flags | cpmc_pkg::FL_TEMP) & ~cpmc_pkg::FL_EXT;
                end
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_TEMP_DOWN:
            begin
                nxt.auto_on = 1'b0;
                if (is_on)
                begin
                    // zero has no wrap: it goes to the floor
                    if ((cur.temperature == 8'd0) || (temp_dec < cfg.temperature_floor))
                        nxt.temperature = cfg.temperature_floor;
                    else
                        nxt.temperature = temp_dec;
                    nxt.flags = (nxt.flags | cpmc_pkg::FL_TEMP) & ~cpmc_pkg::FL_EXT;
                end
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_OUTSIDE:
            begin
                nxt.flags = (nxt.flags ^ cpmc_pkg::FL_EXT) | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_FAN_UP:
            begin
                nxt.auto_on = 1'b0;
                if (is_on && (cur.fan < cpmc_pkg::SPEED_MAX))
                    nxt.fan = cur.fan + 4'd1;
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_FAN_DOWN:
            begin
                nxt.auto_on = 1'b0;
                if (is_on && (cur.fan > cpmc_pkg::SPEED_MIN))
                    nxt.fan = cur.fan - 4'd1;
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            cpmc_pkg::EV_AIR_SELECT:
            begin
                nxt.auto_on = 1'b0;
                if (cur.air != air_position)
                begin
                    nxt.air   = air_position;
                    nxt.flags = nxt.flags | cpmc_pkg::FL_AIR;
                end
                nxt.status = cpmc_pkg::ST_ON;
                nxt.flags  = nxt.flags | cpmc_pkg::FL_FAN | cpmc_pkg::FL_UI;
            end
            default:
            begin
                // unused codes: only the flag clear applies
                nxt.flags = cur.flags & ~clear_mask;
            end
        endcase
    end

endmodule

### hdl/climate_panel_mode_controller_unit.sv
// Climate panel mode controller. Each button item accepted on "button" updates the
// panel state and returns the whole state as one item on "panel_state",
// valid in the cycle after acceptance. A new item is taken every cycle as long as the
// state output is free or being taken in the same cycle, so the sustained rate is one
// item per clock; the single state register, which doubles as the output register,
// sets that figure. Configuration registers are to be written by the user through
// cfg_we/cfg_index/cfg_data only while no item is in flight; not enforced by the block.
// Depends on cpmc_pkg, cpmc_in_if, cpmc_out_if, cpmc_cfg_regs, cpmc_next_state and
// the assertion header.
`include "climate_panel_mode_controller_unit_assert.svh"

module climate_panel_mode_controller_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    cpmc_in_if.sink           button,
    cpmc_out_if.source        panel_state
);

    cpmc_pkg::cfg_t         cfg;
    cpmc_pkg::panel_state_t state_reg;
    cpmc_pkg::panel_state_t state_next;
    cpmc_pkg::panel_state_t event_state;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accept;

    cpmc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpmc_next_state u_next_state (
        .cur          (state_reg),
        .cfg          (cfg),
        .kind         (button.kind),
        .air_position (button.air_position),
        .last_was_on  (button.last_was_on),
        .clear_mask   (button.clear_mask),
        .nxt          (event_state)
    );

    // Handshake: take an item whenever the output slot is free or draining
    assign button.ready = !out_valid_reg || panel_state.ready;
    assign accept       = button.valid && button.ready;

    always_comb
    begin
        state_next     = accept ? event_state : state_reg;
        out_valid_next = accept ? 1'b1 : (out_valid_reg && !panel_state.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpmc_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result item straight from the state register
    assign panel_state.valid            = out_valid_reg;
    assign panel_state.unit_status      = state_reg.status;
    assign panel_state.auto_mode        = state_reg.auto_on;
    assign panel_state.economy_mode     = state_reg.economy;
    assign panel_state.recirculate_mode = state_reg.recirculate;
    assign panel_state.set_temperature  = state_reg.temperature;
    assign panel_state.fan_level        = state_reg.fan;
    assign panel_state.air_setting      = state_reg.air;
    assign panel_state.update_flags     = state_reg.flags;

    // Fan level never leaves its upper limit
    `CPMC_ASSERT_NOW(a_fan_in_range, 1'b1, state_reg.fan <= cpmc_pkg::SPEED_MAX)
    // An accepted item shows up as a result in the next cycle
    `CPMC_ASSERT_NEXT(a_accept_to_result, accept, out_valid_reg)
    // A stalled result keeps the state, so nothing is lost or overwritten
    `CPMC_ASSERT_NEXT(a_stall_holds_state, out_valid_reg && !panel_state.ready,
                      $stable(state_reg) && out_valid_reg)

endmodule

### tb/sv/tb.sv
// Self-checking bench for climate_panel_mode_controller_unit: directed button table,
// then randomized phases over several preset/limit settings, with idle and stall mixes.
// Depends on cpmc_pkg, cpmc_in_if, cpmc_out_if and the controller RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpmc_pkg::*;

    // Kinds the block has no action for
    localparam logic [3:0] KIND_UNUSED_LO = 4'd11;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    localparam int unsigned HOLDOFF_CYCLES = 48;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned PHASE_ITEMS    = 100;
    localparam int unsigned PHASE_COUNT    = 8;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] air_position;
        logic       last_was_on;
        logic [4:0] clear_mask;
    } button_item_t;

    typedef struct packed {
        button_item_t ev;
        logic         typed;
        panel_state_t want;
    } directed_row_t;

    localparam panel_state_t ON_AFTER_RESET = '{ST_ON, 1'b0, 1'b0, 1'b0, 8'd0, 4'd0, 3'd0,
                                                FL_FAN | FL_UI};

    // Directed table; "want" only matters where typed is set
    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{'{KIND_UNUSED_HI, 3'd0, 1'b0, 5'd0},  1'b1, STATE_RESET},
        '{'{EV_TEMP_UP,     3'd0, 1'b0, 5'd0},  1'b1, ON_AFTER_RESET},
        '{'{EV_OFF,         3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_FAN_UP,      3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_OFF,         3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_RESTORE,     3'd0, 1'b1, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_RESTORE,     3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_ECONOMY,     3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_ECONOMY,     3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_RECIRC,      3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_RECIRC,      3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_TEMP_DOWN,   3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_TEMP_UP,     3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_FAN_DOWN,    3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_FAN_UP,      3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_FAN_DOWN,    3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_OUTSIDE,     3'd0, 1'b0, 5'd31}, 1'b0, STATE_RESET},
        '{'{EV_OUTSIDE,     3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_AIR_SELECT,  3'd7, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_AIR_SELECT,  3'd7, 1'b0, 5'd31}, 1'b0, STATE_RESET},
        '{'{EV_AIR_SELECT,  3'd0, 1'b1, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_AUTO,        3'd5, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_AUTO,        3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_OFF,         3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{EV_AUTO,        3'd0, 1'b0, 5'd0},  1'b0, STATE_RESET},
        '{'{KIND_UNUSED_LO, 3'd2, 1'b1, 5'd31}, 1'b0, STATE_RESET}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    cpmc_in_if  button_ch ();
    cpmc_out_if state_ch ();

    climate_panel_mode_controller_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .button      (button_ch),
        .panel_state (state_ch)
    );

    // Predictor state and the panel states still owed by the block
    panel_state_t model_panel;
    cfg_t         model_cfg;
    panel_state_t expected_panel [$];

    logic         row_typed;
    panel_state_t row_want;
    logic         holdoff_req;
    int unsigned  holdoff_left;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Next panel state after one button item
    function automatic panel_state_t panel_after_event(input panel_state_t s, input cfg_t c,
                                                       input button_item_t b);
        panel_state_t n;
        logic         was_on;
        logic [8:0]   temp_up;
        int           temp_down;
        logic [3:0]   fan_pick;
        n = s;
        n.flags = s.flags & ~b.clear_mask;
        was_on = (s.status == ST_ON);
        case (b.kind)
            EV_RESTORE:
            begin
                if (b.last_was_on)
                begin
                    n.status = ST_ON;
                    n.flags |= FL_FAN | FL_AIR;
                end
                else
                    n.status = ST_OFF;
                n.flags |= FL_UI;
            end
            EV_OFF:
            begin
                if (was_on)
                begin
                    n.status = ST_OFF;
                    n.flags &= ~(FL_TEMP | FL_AIR | FL_EXT);
                    n.flags |= FL_FAN;
                end
                n.flags |= FL_UI;
            end
            EV_AUTO:
            begin
                if (was_on)
                    n.auto_on = ~n.auto_on;
                // engaging auto loads the presets, fan clamped into its limits
                if (n.auto_on)
                begin
                    fan_pick = c.preset_fan_speed;
                    if (fan_pick < SPEED_MIN)
                        fan_pick = SPEED_MIN;
                    if (fan_pick > SPEED_MAX)
                        fan_pick = SPEED_MAX;
                    n.economy     = c.preset_economy;
                    n.recirculate = c.preset_recirculate;
                    n.air         = c.preset_air_position;
                    n.temperature = c.preset_temperature;
                    n.fan         = fan_pick;
                    n.flags |= FL_AIR;
                    n.flags &= ~FL_EXT;
                end
            end
            EV_ECONOMY:
            begin
                n.auto_on = 1'b0;
                n.economy = was_on ? ~n.economy : 1'b1;
            end
            EV_RECIRC:
            begin
                n.auto_on = 1'b0;
                n.recirculate = was_on ? ~n.recirculate : 1'b1;
            end
            EV_TEMP_UP:
            begin
                n.auto_on = 1'b0;
                if (was_on)
                begin
                    temp_up = {1'b0, n.temperature} + 9'd1;
                    if (temp_up > {1'b0, c.temperature_ceiling})
                        temp_up = {1'b0, c.temperature_ceiling};
                    n.temperature = temp_up[7:0];
                    n.flags |= FL_TEMP;
                    n.flags &= ~FL_EXT;
                end
            end
            EV_TEMP_DOWN:
            begin
                n.auto_on = 1'b0;
                if (was_on)
                begin
                    temp_down = int'(n.temperature) - 1;
                    if (temp_down < int'(c.temperature_floor))
                        temp_down = int'(c.temperature_floor);
                    n.temperature = temp_down[7:0];
                    n.flags |= FL_TEMP;
                    n.flags &= ~FL_EXT;
                end
            end
            EV_OUTSIDE:
            begin
                n.flags ^= FL_EXT;
                n.flags |= FL_UI;
            end
            EV_FAN_UP:
            begin
                n.auto_on = 1'b0;
                if (was_on && n.fan < SPEED_MAX)
                    n.fan = n.fan + 4'd1;
            end
            EV_FAN_DOWN:
            begin
                n.auto_on = 1'b0;
                if (was_on && n.fan > SPEED_MIN)
                    n.fan = n.fan - 4'd1;
            end
            EV_AIR_SELECT:
            begin
                n.auto_on = 1'b0;
                if (n.air != b.air_position)
                begin
                    n.air = b.air_position;
                    n.flags |= FL_AIR;
                end
            end
            default:
            begin
            end
        endcase
        // every handled kind but restore, off and outside ends powered on
        if (b.kind >= EV_AUTO && b.kind <= EV_AIR_SELECT && b.kind != EV_OUTSIDE)
        begin
            n.status = ST_ON;
            n.flags |= FL_FAN | FL_UI;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_panel(input panel_state_t want);
        if (state_ch.unit_status !== want.status)
            report_mismatch($sformatf("unit_status %0d want %0d",
                                      state_ch.unit_status, want.status));
        if (state_ch.auto_mode !== want.auto_on)
            report_mismatch($sformatf("auto_mode %0d want %0d",
                                      state_ch.auto_mode, want.auto_on));
        if (state_ch.economy_mode !== want.economy)
            report_mismatch($sformatf("economy_mode %0d want %0d",
                                      state_ch.economy_mode, want.economy));
        if (state_ch.recirculate_mode !== want.recirculate)
            report_mismatch($sformatf("recirculate_mode %0d want %0d",
                                      state_ch.recirculate_mode, want.recirculate));
        if (state_ch.set_temperature !== want.temperature)
            report_mismatch($sformatf("set_temperature %0d want %0d",
                                      state_ch.set_temperature, want.temperature));
        if (state_ch.fan_level !== want.fan)
            report_mismatch($sformatf("fan_level %0d want %0d",
                                      state_ch.fan_level, want.fan));
        if (state_ch.air_setting !== want.air)
            report_mismatch($sformatf("air_setting %0d want %0d",
                                      state_ch.air_setting, want.air));
        if (state_ch.update_flags !== want.flags)
            report_mismatch($sformatf("update_flags %b want %b",
                                      state_ch.update_flags, want.flags));
    endtask

    // Result checking, prediction on input acceptance, and the stall watchdog
    always @(posedge clk)
    begin
        button_item_t taken;
        panel_state_t next;
        if (rst_n)
        begin
            if (state_ch.valid && state_ch.ready)
            begin
                if (expected_panel.size() == 0)
                    report_mismatch("panel state item with none expected");
                else
                    check_panel(expected_panel.pop_front());
            end
            if (button_ch.valid && button_ch.ready)
            begin
                taken = '{button_ch.kind, button_ch.air_position, button_ch.last_was_on,
                          button_ch.clear_mask};
                next = panel_after_event(model_panel, model_cfg, taken);
                model_panel = next;
                expected_panel.push_back(row_typed ? row_want : next);
            end
            if ((button_ch.valid && button_ch.ready) || (state_ch.valid && state_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            state_ch.ready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            state_ch.ready <= 1'b0;
        end
        else
            state_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item and return at the edge that accepts it
    task automatic send_event(input button_item_t ev, input logic typed,
                              input panel_state_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            button_ch.valid <= 1'b0;
            @(posedge clk);
        end
        button_ch.valid        <= 1'b1;
        button_ch.kind         <= ev.kind;
        button_ch.air_position <= ev.air_position;
        button_ch.last_was_on  <= ev.last_was_on;
        button_ch.clear_mask   <= ev.clear_mask;
        row_typed              <= typed;
        row_want               <= want;
        @(posedge clk);
        while (!button_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed result has come back; the first
    // edge lets the monitor log an item accepted at the edge just passed
    task automatic drain_results();
        button_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_panel.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        write_reg(CFG_PRESET_ECONOMY, {7'd0, s.preset_economy});
        write_reg(CFG_PRESET_RECIRC,  {7'd0, s.preset_recirculate});
        write_reg(CFG_PRESET_AIR,     {5'd0, s.preset_air_position});
        write_reg(CFG_PRESET_TEMP,    s.preset_temperature);
        write_reg(CFG_PRESET_FAN,     {4'd0, s.preset_fan_speed});
        write_reg(CFG_TEMP_FLOOR,     s.temperature_floor);
        write_reg(CFG_TEMP_CEILING,   s.temperature_ceiling);
        cfg_we <= 1'b0;
        model_cfg = s;
    endtask

    // First phases hit the extremes, the rest are random
    function automatic cfg_t settings_for(input int unsigned phase);
        cfg_t s;
        case (phase)
            0: s = '{1'b1, 1'b1, 3'd7, 8'd255, 4'd15, 8'd255, 8'd254};
            1: s = '{1'b0, 1'b0, 3'd0, 8'd0, 4'd0, 8'd0, 8'd0};
            2: s = '{1'b1, 1'b0, 3'd3, 8'd22, 4'd8, 8'd1, 8'd254};
            3: s = '{1'b0, 1'b1, 3'd4, 8'd200, 4'd1, 8'd180, 8'd210};
            default:
            begin
                s.preset_economy      = 1'($urandom_range(1));
                s.preset_recirculate  = 1'($urandom_range(1));
                s.preset_air_position = 3'($urandom_range(7));
                s.preset_temperature  = 8'($urandom_range(255));
                s.preset_fan_speed    = 4'($urandom_range(15));
                s.temperature_floor   = 8'($urandom_range(40, 1));
                s.temperature_ceiling = 8'($urandom_range(254, 20));
            end
        endcase
        return s;
    endfunction

    // Mostly powered-on panel activity; unused kinds now and then
    function automatic logic [3:0] pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
        if (r < 9)  return EV_RESTORE;
        if (r < 14) return EV_OFF;
        if (r < 22) return EV_AUTO;
        if (r < 30) return EV_ECONOMY;
        if (r < 37) return EV_RECIRC;
        if (r < 52) return EV_TEMP_UP;
        if (r < 67) return EV_TEMP_DOWN;
        if (r < 72) return EV_OUTSIDE;
        if (r < 82) return EV_FAN_UP;
        if (r < 92) return EV_FAN_DOWN;
        return EV_AIR_SELECT;
    endfunction

    initial
    begin
        button_item_t ev;
        int unsigned  sent;
        int unsigned  burst;
        int unsigned  mode;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_PRESET_ECONOMY;
        cfg_data               = 8'd0;
        button_ch.valid        = 1'b0;
        button_ch.kind         = EV_RESTORE;
        button_ch.air_position = 3'd0;
        button_ch.last_was_on  = 1'b0;
        button_ch.clear_mask   = 5'd0;
        state_ch.ready         = 1'b0;
        row_typed              = 1'b0;
        row_want               = STATE_RESET;
        holdoff_req            = 1'b0;
        holdoff_left           = 0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        error_count            = 0;
        quiet_cycles           = 0;
        model_panel            = STATE_RESET;
        model_cfg              = '{1'b0, 1'b0, 3'd0, 8'd22, 4'd1, 8'd16, 8'd30};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        for (int i = 0; i < 26; i++)
            send_event(DIRECTED_ROWS[i].ev, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // Random phases, each with its own settings and idle mix
        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            load_settings(settings_for(phase));
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 58 : (mode == 3) ? 16 : 0;
            recv_stall_pct = (mode == 2) ? 58 : (mode == 3) ? 16 : 0;
            if (phase == 4)
            begin
                // long receiver hold-off while items keep coming
                holdoff_req <= 1'b1;
                @(posedge clk);
                holdoff_req <= 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                ev.kind = pick_kind();
                if (ev.kind >= EV_TEMP_UP && ev.kind <= EV_FAN_DOWN && ev.kind != EV_OUTSIDE)
                    burst = $urandom_range(20, 1);
                else
                    burst = $urandom_range(2, 1);
                for (int unsigned k = 0; k < burst; k++)
                begin
                    ev.air_position = 3'($urandom_range(7));
                    ev.last_was_on  = 1'($urandom_range(1));
                    ev.clear_mask   = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31));
                    send_event(ev, 1'b0, STATE_RESET);
                    sent++;
                end
                // occasionally let the block run empty
                if ($urandom_range(24) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (2) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
